@@ design/tpa_pkg.sv @@
// Package for the token position assigner: widths, status codes, register
// indexes, the classified-token record and the saturating position helper.
// No dependencies.
`default_nettype none

package tpa_pkg;

    localparam int POS_WIDTH     = 20;
    localparam int GRID_SIDE_MAX = 1024;

    localparam int TOKEN_W   = 18;
    localparam int FRAMES_W  = 8;
    localparam int SIDE_W    = 10;
    localparam int HALF_W    = SIDE_W - 1;
    localparam int IMG_CNT_W = 8;
    localparam int STATUS_W  = 3;

    // Wide enough for position + half side + 1 without wrap
    localparam int SUM_W = ((POS_WIDTH > HALF_W) ? POS_WIDTH : HALF_W) + 2;
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_VISION_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_PAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_PAD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VISION_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_IMGS = 3'd4;

    localparam logic [TOKEN_W-1:0] VIDEO_PAD_RESET = 18'd151656;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_GRID    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXTRA_BLOCK = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PAD     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PAD_MISMATCH = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_END      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_MISSING     = 3'd7;

    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef struct packed {
        logic [TOKEN_W-1:0]   open_tok;
        logic [TOKEN_W-1:0]   image_pad;
        logic [TOKEN_W-1:0]   video_pad;
        logic [TOKEN_W-1:0]   close_tok;
        logic [IMG_CNT_W-1:0] expected_images;
    } t_cfg;

    typedef struct packed {
        logic [TOKEN_W-1:0]  tok;
        logic                is_start;
        logic                is_pad;
        logic                is_end;
        logic                grid_bad;
        logic [FRAMES_W-1:0] frames;
        logic [HALF_W-1:0]   half_rows;
        logic [HALF_W-1:0]   half_cols;
        logic [HALF_W-1:0]   max_half;
        logic                fin;
    } t_cls;

    function automatic logic [POS_WIDTH-1:0] sat_pos(input logic [SUM_W-1:0] s);
        logic [POS_WIDTH-1:0] r;
        if (s > SUM_W'(POS_MAX)) begin
            r = POS_MAX;
        end else begin
            r = s[POS_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/tpa_in_if.sv @@
// Input token channel: valid/ready handshake with the token fields.
// Depends on tpa_pkg for field widths.
`default_nettype none

interface tpa_in_if;
    logic                          valid;
    logic                          ready;
    logic [tpa_pkg::TOKEN_W-1:0]   token_id;
    logic [tpa_pkg::FRAMES_W-1:0]  grid_frames;
    logic [tpa_pkg::SIDE_W-1:0]    grid_rows;
    logic [tpa_pkg::SIDE_W-1:0]    grid_cols;
    logic                          final_token;

    modport source (output valid, token_id, grid_frames, grid_rows, grid_cols,
                    final_token, input ready);
    modport sink   (input valid, token_id, grid_frames, grid_rows, grid_cols,
                    final_token, output ready);
endinterface

`default_nettype wire

@@ design/tpa_out_if.sv @@
// Output position channel: valid/ready handshake with the result fields.
// Depends on tpa_pkg for field widths.
`default_nettype none

interface tpa_out_if;
    logic                           valid;
    logic                           ready;
    logic [tpa_pkg::POS_WIDTH-1:0]  pos_time;
    logic [tpa_pkg::POS_WIDTH-1:0]  pos_row;
    logic [tpa_pkg::POS_WIDTH-1:0]  pos_col;
    logic                           is_image_row;
    logic [tpa_pkg::STATUS_W-1:0]   status;
    logic                           last_result;

    modport source (output valid, pos_time, pos_row, pos_col, is_image_row, status,
                    last_result, input ready);
    modport sink   (input valid, pos_time, pos_row, pos_col, is_image_row, status,
                    last_result, output ready);
endinterface

`default_nettype wire

@@ design/tpa_front.sv @@
// Front stage: accepts tokens, compares them against the configured ids and
// checks the grid, then registers the classified record. Uses tpa_pkg, tpa_in_if.
`default_nettype none

module tpa_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire tpa_pkg::t_cfg    i_cfg,
    tpa_in_if.sink                i_tok,
    output logic                  o_cls_valid,
    input  wire                   i_cls_ready,
    output tpa_pkg::t_cls         o_cls
);

    logic          r_valid;
    tpa_pkg::t_cls r_cls;
    tpa_pkg::t_cls n_cls;
    logic          w_take;

    logic [tpa_pkg::HALF_W-1:0] w_half_rows;
    logic [tpa_pkg::HALF_W-1:0] w_half_cols;
    logic [tpa_pkg::HALF_W-1:0] w_frames_ext;
    logic [tpa_pkg::HALF_W-1:0] w_max;

    assign i_tok.ready = !r_valid || i_cls_ready;
    assign w_take      = i_tok.valid && i_tok.ready;

    assign w_half_rows  = i_tok.grid_rows[tpa_pkg::SIDE_W-1:1];
    assign w_half_cols  = i_tok.grid_cols[tpa_pkg::SIDE_W-1:1];
    assign w_frames_ext = tpa_pkg::HALF_W'(i_tok.grid_frames);

    always_comb begin
        w_max = w_frames_ext;
        if (w_half_rows > w_max) begin
            w_max = w_half_rows;
        end
        if (w_half_cols > w_max) begin
            w_max = w_half_cols;
        end
    end

    always_comb begin
        n_cls.tok       = i_tok.token_id;
        n_cls.is_start  = (i_tok.token_id == i_cfg.open_tok);
        n_cls.is_pad    = (i_tok.token_id == i_cfg.image_pad) ||
                          (i_tok.token_id == i_cfg.video_pad);
        n_cls.is_end    = (i_tok.token_id == i_cfg.close_tok);
        n_cls.grid_bad  = (i_tok.grid_frames == '0) ||
                          (i_tok.grid_rows == '0) || (i_tok.grid_cols == '0) ||
                          i_tok.grid_rows[0] || i_tok.grid_cols[0] ||
                          (int'(i_tok.grid_rows) >= tpa_pkg::GRID_SIDE_MAX) ||
                          (int'(i_tok.grid_cols) >= tpa_pkg::GRID_SIDE_MAX);
        n_cls.frames    = i_tok.grid_frames;
        n_cls.half_rows = w_half_rows;
        n_cls.half_cols = w_half_cols;
        n_cls.max_half  = w_max;
        n_cls.fin       = i_tok.final_token;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_valid <= 1'b1;
                r_cls   <= n_cls;
            end else if (i_cls_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_cls_valid = r_valid;
    assign o_cls       = r_cls;

endmodule

`default_nettype wire

@@ design/tpa_queue.sv @@
// Short register queue between the classifier and the position engine.
// Uses tpa_pkg for the record type and depth.
`default_nettype none

module tpa_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_wr_valid,
    output logic                  o_wr_ready,
    input  wire tpa_pkg::t_cls    i_wr_data,
    output logic                  o_rd_valid,
    input  wire                   i_rd_ready,
    output tpa_pkg::t_cls         o_rd_data
);

    tpa_pkg::t_cls                r_mem [tpa_pkg::QUEUE_DEPTH];
    logic [tpa_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [tpa_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [tpa_pkg::QUEUE_AW:0]   r_count;
    logic                         w_push;
    logic                         w_pop;

    assign o_wr_ready = (r_count != (tpa_pkg::QUEUE_AW+1)'(tpa_pkg::QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wr_ptr] <= i_wr_data;
                r_wr_ptr        <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/tpa_back.sv @@
// Position engine: walks the prompt phases, runs the frame/row/column
// counters, tracks the sticky error and registers one result per token.
// Uses tpa_pkg and tpa_out_if.
`default_nettype none

module tpa_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire [tpa_pkg::IMG_CNT_W-1:0]     i_expected_images,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire tpa_pkg::t_cls               i_cls,
    tpa_out_if.source                        o_pos
);

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_PAD_FIRST,
        PH_PAD_RUN,
        PH_END
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [tpa_pkg::POS_WIDTH-1:0]   r_np, n_np;
    logic [tpa_pkg::IMG_CNT_W-1:0]   r_seen, n_seen;
    logic [tpa_pkg::TOKEN_W-1:0]     r_held, n_held;
    logic [tpa_pkg::FRAMES_W-1:0]    r_frame, n_frame;
    logic [tpa_pkg::HALF_W-1:0]      r_row, n_row;
    logic [tpa_pkg::HALF_W-1:0]      r_col, n_col;
    logic [tpa_pkg::FRAMES_W-1:0]    r_lfr, n_lfr;
    logic [tpa_pkg::HALF_W-1:0]      r_lhr, n_lhr;
    logic [tpa_pkg::HALF_W-1:0]      r_lhc, n_lhc;
    logic [tpa_pkg::HALF_W-1:0]      r_lmax, n_lmax;
    logic [tpa_pkg::STATUS_W-1:0]    r_err, n_err;

    logic                            r_ovalid;
    logic [tpa_pkg::POS_WIDTH-1:0]   r_pt, r_pr, r_pc;
    logic                            r_img;
    logic [tpa_pkg::STATUS_W-1:0]    r_status;
    logic                            r_last;

    logic [tpa_pkg::POS_WIDTH-1:0]   w_pt, w_pr, w_pc;
    logic                            w_img;
    logic [tpa_pkg::STATUS_W-1:0]    w_code;
    logic                            w_as_text;
    logic                            w_deq;

    logic [tpa_pkg::POS_WIDTH-1:0]   w_end_pos, w_end_next, w_text_next;
    logic [tpa_pkg::POS_WIDTH-1:0]   w_base, w_base_next;
    logic [tpa_pkg::POS_WIDTH-1:0]   w_pad_t, w_pad_r, w_pad_c;
    logic [tpa_pkg::HALF_W:0]        w_col_inc, w_row_inc;
    logic [tpa_pkg::FRAMES_W:0]      w_frame_inc;

    assign o_ready = !r_ovalid || o_pos.ready;
    assign w_deq   = i_valid && o_ready;

    // Position sums, all saturating
    assign w_end_pos   = tpa_pkg::sat_pos(tpa_pkg::SUM_W'(r_np) + tpa_pkg::SUM_W'(r_lmax));
    assign w_end_next  = tpa_pkg::sat_pos(tpa_pkg::SUM_W'(r_np) + tpa_pkg::SUM_W'(r_lmax)
                                          + tpa_pkg::SUM_W'(1));
    assign w_text_next = tpa_pkg::sat_pos(tpa_pkg::SUM_W'(r_np) + tpa_pkg::SUM_W'(1));
    assign w_base      = (r_phase == PH_END) ? w_end_pos  : r_np;
    assign w_base_next = (r_phase == PH_END) ? w_end_next : w_text_next;
    assign w_pad_t     = tpa_pkg::sat_pos(tpa_pkg::SUM_W'(r_np) + tpa_pkg::SUM_W'(r_frame));
    assign w_pad_r     = tpa_pkg::sat_pos(tpa_pkg::SUM_W'(r_np) + tpa_pkg::SUM_W'(r_row));
    assign w_pad_c     = tpa_pkg::sat_pos(tpa_pkg::SUM_W'(r_np) + tpa_pkg::SUM_W'(r_col));
    assign w_col_inc   = {1'b0, r_col} + 1'b1;
    assign w_row_inc   = {1'b0, r_row} + 1'b1;
    assign w_frame_inc = {1'b0, r_frame} + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_np      = r_np;
        n_seen    = r_seen;
        n_held    = r_held;
        n_frame   = r_frame;
        n_row     = r_row;
        n_col     = r_col;
        n_lfr     = r_lfr;
        n_lhr     = r_lhr;
        n_lhc     = r_lhc;
        n_lmax    = r_lmax;
        n_err     = r_err;
        w_code    = tpa_pkg::ST_OK;
        w_as_text = 1'b0;
        w_img     = 1'b0;
        w_pt      = '0;
        w_pr      = '0;
        w_pc      = '0;

        if (r_err == tpa_pkg::ST_OK) begin
            unique case (r_phase)
                PH_PAD_FIRST, PH_PAD_RUN: begin
                    if (i_cls.fin) begin
                        w_code = tpa_pkg::ST_TRUNCATED;
                    end else if (r_phase == PH_PAD_FIRST && !i_cls.is_pad) begin
                        w_code = tpa_pkg::ST_BAD_PAD;
                    end else if (r_phase == PH_PAD_RUN && i_cls.tok != r_held) begin
                        w_code = tpa_pkg::ST_PAD_MISMATCH;
                    end else begin
                        if (r_phase == PH_PAD_FIRST) begin
                            n_held = i_cls.tok;
                        end
                        w_pt    = w_pad_t;
                        w_pr    = w_pad_r;
                        w_pc    = w_pad_c;
                        w_img   = 1'b1;
                        n_phase = PH_PAD_RUN;
                        // advance column, carry into row, then frame
                        if (w_col_inc >= {1'b0, r_lhc}) begin
                            n_col = '0;
                            if (w_row_inc >= {1'b0, r_lhr}) begin
                                n_row   = '0;
                                n_frame = w_frame_inc[tpa_pkg::FRAMES_W-1:0];
                                if (w_frame_inc >= {1'b0, r_lfr}) begin
                                    n_phase = PH_END;
                                end
                            end else begin
                                n_row = w_row_inc[tpa_pkg::HALF_W-1:0];
                            end
                        end else begin
                            n_col = w_col_inc[tpa_pkg::HALF_W-1:0];
                        end
                    end
                end
                PH_END: begin
                    if (!i_cls.is_end) begin
                        w_code = tpa_pkg::ST_NO_END;
                    end else begin
                        n_np      = w_end_pos;
                        n_phase   = PH_TEXT;
                        w_as_text = 1'b1;
                    end
                end
                PH_TEXT: begin
                    w_as_text = 1'b1;
                end
                default: begin
                    w_as_text = 1'b1;
                end
            endcase

            if (w_as_text) begin
                if (i_cls.is_start) begin
                    if (r_seen >= i_expected_images) begin
                        w_code = tpa_pkg::ST_EXTRA_BLOCK;
                    end else if (i_cls.grid_bad) begin
                        w_code = tpa_pkg::ST_BAD_GRID;
                    end else begin
                        n_lfr   = i_cls.frames;
                        n_lhr   = i_cls.half_rows;
                        n_lhc   = i_cls.half_cols;
                        n_lmax  = i_cls.max_half;
                        n_frame = '0;
                        n_row   = '0;
                        n_col   = '0;
                        n_seen  = r_seen + 1'b1;
                        w_pt    = w_base;
                        w_pr    = w_base;
                        w_pc    = w_base;
                        n_np    = w_base_next;
                        n_phase = PH_PAD_FIRST;
                        if (i_cls.fin) begin
                            w_code = tpa_pkg::ST_TRUNCATED;
                        end
                    end
                end else begin
                    w_pt = w_base;
                    w_pr = w_base;
                    w_pc = w_base;
                    n_np = w_base_next;
                end
                if (w_code == tpa_pkg::ST_OK && i_cls.fin && n_seen != i_expected_images) begin
                    w_code = tpa_pkg::ST_MISSING;
                end
            end

            if (w_code != tpa_pkg::ST_OK) begin
                n_err = w_code;
            end
        end

        if (n_err != tpa_pkg::ST_OK) begin
            w_pt  = '0;
            w_pr  = '0;
            w_pc  = '0;
            w_img = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TEXT;
            r_np     <= '0;
            r_seen   <= '0;
            r_held   <= '0;
            r_frame  <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_lfr    <= '0;
            r_lhr    <= '0;
            r_lhc    <= '0;
            r_lmax   <= '0;
            r_err    <= tpa_pkg::ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            if (w_deq) begin
                r_ovalid <= 1'b1;
                r_pt     <= w_pt;
                r_pr     <= w_pr;
                r_pc     <= w_pc;
                r_img    <= w_img;
                r_status <= n_err;
                r_last   <= i_cls.fin;
                if (i_cls.fin) begin
                    // prompt closed: drop all per-prompt state
                    r_phase <= PH_TEXT;
                    r_np    <= '0;
                    r_seen  <= '0;
                    r_held  <= '0;
                    r_frame <= '0;
                    r_row   <= '0;
                    r_col   <= '0;
                    r_lfr   <= '0;
                    r_lhr   <= '0;
                    r_lhc   <= '0;
                    r_lmax  <= '0;
                    r_err   <= tpa_pkg::ST_OK;
                end else begin
                    r_phase <= n_phase;
                    r_np    <= n_np;
                    r_seen  <= n_seen;
                    r_held  <= n_held;
                    r_frame <= n_frame;
                    r_row   <= n_row;
                    r_col   <= n_col;
                    r_lfr   <= n_lfr;
                    r_lhr   <= n_lhr;
                    r_lhc   <= n_lhc;
                    r_lmax  <= n_lmax;
                    r_err   <= n_err;
                end
            end else if (o_pos.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_pos.valid        = r_ovalid;
    assign o_pos.pos_time     = r_pt;
    assign o_pos.pos_row      = r_pr;
    assign o_pos.pos_col      = r_pc;
    assign o_pos.is_image_row = r_img;
    assign o_pos.status       = r_status;
    assign o_pos.last_result  = r_last;

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_deq && r_err != tpa_pkg::ST_OK && !i_cls.fin) |=> (r_err == $past(r_err)))
        else $error("held error code changed inside a prompt");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_deq && i_cls.fin) |=> (r_phase == PH_TEXT && r_err == tpa_pkg::ST_OK &&
                                  r_np == '0 && r_seen == '0))
        else $error("prompt state not cleared after final token");

    a_err_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_deq && n_err != tpa_pkg::ST_OK) |=> (r_pt == '0 && r_pr == '0 && r_pc == '0 &&
                                              !r_img))
        else $error("nonzero position emitted under an error");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_pos.ready) |=> (r_ovalid && $stable(r_pt) && $stable(r_status)))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

@@ design/multimodal_token_position_assigner_core.sv @@
// Top level of the token position assigner: configuration registers,
// classifier front, queue and position engine. Uses tpa_pkg and the channel interfaces.
// Path: a token is registered in the front stage, then in the queue, then in the engine's result register.
// Throughput: one token per cycle while the receiver takes results; the engine's per-token state update sets it.
// Reset: synchronous, active low; clears all prompt state and loads register defaults.
`default_nettype none

module multimodal_token_position_assigner_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_wr_en,
    input  wire [tpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [tpa_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    tpa_in_if.sink                            i_tok,
    tpa_out_if.source                         o_pos
);

    tpa_pkg::t_cfg r_cfg;

    logic          w_f_valid;
    logic          w_f_ready;
    tpa_pkg::t_cls w_f_cls;
    logic          w_q_valid;
    logic          w_q_ready;
    tpa_pkg::t_cls w_q_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_tok        <= '0;
            r_cfg.image_pad       <= '0;
            r_cfg.video_pad       <= tpa_pkg::VIDEO_PAD_RESET;
            r_cfg.close_tok       <= '0;
            r_cfg.expected_images <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tpa_pkg::CFG_VISION_START:  r_cfg.open_tok     <= i_cfg_wdata;
                tpa_pkg::CFG_IMAGE_PAD:     r_cfg.image_pad    <= i_cfg_wdata;
                tpa_pkg::CFG_VIDEO_PAD:     r_cfg.video_pad    <= i_cfg_wdata;
                tpa_pkg::CFG_VISION_END:    r_cfg.close_tok    <= i_cfg_wdata;
                tpa_pkg::CFG_EXPECTED_IMGS: begin
                    r_cfg.expected_images <= i_cfg_wdata[tpa_pkg::IMG_CNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    tpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_tok       (i_tok),
        .o_cls_valid (w_f_valid),
        .i_cls_ready (w_f_ready),
        .o_cls       (w_f_cls)
    );

    tpa_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_f_valid),
        .o_wr_ready (w_f_ready),
        .i_wr_data  (w_f_cls),
        .o_rd_valid (w_q_valid),
        .i_rd_ready (w_q_ready),
        .o_rd_data  (w_q_cls)
    );

    tpa_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_expected_images (r_cfg.expected_images),
        .i_valid           (w_q_valid),
        .o_ready           (w_q_ready),
        .i_cls             (w_q_cls),
        .o_pos             (o_pos)
    );

endmodule

`default_nettype wire

@@ bench/tb_multimodal_token_position_assigner_core.sv @@
`timescale 1ns / 100ps
// Testbench for multimodal_token_position_assigner_core: a directed table and then random
// prompts, with every result checked against its table entry or a position predictor kept in this file.
// Depends on tpa_pkg, tpa_in_if, tpa_out_if and the core.

module tb_multimodal_token_position_assigner_core;
    import tpa_pkg::*;

    localparam int WD_LIMIT     = 4000;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int RAND_PER_SET = 165;
    localparam int MAX_REPORTS  = 10;
    localparam int CFG_ROW      = 4;

    // token ids used by the directed rows once the registers are programmed
    localparam logic [TOKEN_W-1:0] D_START = 18'd100;
    localparam logic [TOKEN_W-1:0] D_IMG   = 18'd101;
    localparam logic [TOKEN_W-1:0] D_VID   = 18'd102;
    localparam logic [TOKEN_W-1:0] D_END   = 18'd103;

    localparam longint unsigned POS_LIMIT = (64'd1 << POS_WIDTH) - 64'd1;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_FIRST_PAD,
        PH_PAD_RUN,
        PH_WAIT_END
    } blk_phase_e;

    typedef struct packed {
        logic [POS_WIDTH-1:0] pt;
        logic [POS_WIDTH-1:0] pr;
        logic [POS_WIDTH-1:0] pc;
        logic                 img;
        logic [STATUS_W-1:0]  st;
        logic                 last;
    } pos_res_t;

    typedef struct packed {
        logic [TOKEN_W-1:0]  tok;
        logic [FRAMES_W-1:0] frames;
        logic [SIDE_W-1:0]   rows;
        logic [SIDE_W-1:0]   cols;
        logic                fin;
        logic                typed;
        pos_res_t            exp;
    } tok_item_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    tpa_in_if  tok_if ();
    tpa_out_if pos_if ();

    multimodal_token_position_assigner_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tok       (tok_if),
        .o_pos       (pos_if)
    );

    always #5 i_clk = ~i_clk;

    // register copy
    logic [TOKEN_W-1:0]   cfg_start, cfg_img_pad, cfg_vid_pad, cfg_end;
    logic [IMG_CNT_W-1:0] cfg_n_img;

    // prompt state of the predictor
    logic [POS_WIDTH-1:0] m_next;
    blk_phase_e           m_phase;
    logic [IMG_CNT_W-1:0] m_seen;
    logic [TOKEN_W-1:0]   m_pad;
    logic [FRAMES_W-1:0]  m_f, m_lf;
    logic [HALF_W-1:0]    m_r, m_c, m_lr, m_lc;
    logic [STATUS_W-1:0]  m_err;

    pos_res_t  exp_q[$];
    tok_item_t dir_tab[$];
    tok_item_t prompt_q[$];

    pos_res_t  drv_exp;
    logic      drv_typed = 1'b0;
    pos_res_t  want, got, pred;

    int  snd_idle_pct = 18;
    int  rcv_idle_pct = 77;
    bit  stall_req = 1'b0;
    bit  stall_done = 1'b0;
    int  stall_left = 0;
    bit  big_done = 1'b0;
    int  quiet_cyc = 0;

    int  bad_cnt = 0;
    int  n_tok_in = 0;
    int  n_res_out = 0;
    int  n_err_res = 0;
    int  n_blocks = 0;
    logic [7:0] st_seen = 8'h00;

    function automatic void add_row(tok_item_t it);
        dir_tab.insert(dir_tab.size(), it);
    endfunction

    function automatic void add_tok(tok_item_t it);
        prompt_q.insert(prompt_q.size(), it);
    endfunction

    function automatic logic [POS_WIDTH-1:0] pos_add(logic [POS_WIDTH-1:0] a,
                                                     int unsigned b);
        longint unsigned s;
        s = longint'(a) + longint'(b);
        if (s > POS_LIMIT) begin
            return POS_WIDTH'(POS_LIMIT);
        end
        return POS_WIDTH'(s);
    endfunction

    function automatic void clear_prompt_state();
        m_next = '0;
        m_phase = PH_TEXT;
        m_seen = '0;
        m_pad = '0;
        m_f = '0;
        m_r = '0;
        m_c = '0;
        m_lf = '0;
        m_lr = '0;
        m_lc = '0;
        m_err = ST_OK;
    endfunction

    function automatic pos_res_t assign_positions(logic [TOKEN_W-1:0] tok,
                                                  logic [FRAMES_W-1:0] fr,
                                                  logic [SIDE_W-1:0] rw,
                                                  logic [SIDE_W-1:0] cl,
                                                  logic fin);
        pos_res_t             r;
        logic [STATUS_W-1:0]  code;
        logic                 as_text;
        int unsigned          adv;
        r = '0;
        code = ST_OK;
        as_text = 1'b0;
        if (m_err == ST_OK) begin
            if (m_phase == PH_FIRST_PAD || m_phase == PH_PAD_RUN) begin
                if (fin) begin
                    code = ST_TRUNCATED;
                end else if (m_phase == PH_FIRST_PAD && tok != cfg_img_pad &&
                             tok != cfg_vid_pad) begin
                    code = ST_BAD_PAD;
                end else if (m_phase == PH_PAD_RUN && tok != m_pad) begin
                    code = ST_PAD_MISMATCH;
                end else begin
                    if (m_phase == PH_FIRST_PAD) m_pad = tok;
                    r.pt = pos_add(m_next, m_f);
                    r.pr = pos_add(m_next, m_r);
                    r.pc = pos_add(m_next, m_c);
                    r.img = 1'b1;
                    m_phase = PH_PAD_RUN;
                    // column counter wraps into row, row into frame
                    m_c = m_c + 1'b1;
                    if (m_c >= m_lc) begin
                        m_c = '0;
                        m_r = m_r + 1'b1;
                        if (m_r >= m_lr) begin
                            m_r = '0;
                            m_f = m_f + 1'b1;
                            if (m_f >= m_lf) m_phase = PH_WAIT_END;
                        end
                    end
                end
            end else if (m_phase == PH_WAIT_END) begin
                if (tok != cfg_end) begin
                    code = ST_NO_END;
                end else begin
                    adv = m_lf;
                    if (m_lr > adv) adv = m_lr;
                    if (m_lc > adv) adv = m_lc;
                    m_next = pos_add(m_next, adv);
                    m_phase = PH_TEXT;
                    as_text = 1'b1;
                end
            end else begin
                as_text = 1'b1;
            end

            // an accepted end falls through here, so it may also open a block
            if (as_text) begin
                if (tok == cfg_start) begin
                    if (m_seen >= cfg_n_img) begin
                        code = ST_EXTRA_BLOCK;
                    end else if (fr == 0 || rw == 0 || cl == 0 || rw[0] || cl[0] ||
                                 rw >= GRID_SIDE_MAX || cl >= GRID_SIDE_MAX) begin
                        code = ST_BAD_GRID;
                    end else begin
                        m_lf = fr;
                        m_lr = rw[SIDE_W-1:1];
                        m_lc = cl[SIDE_W-1:1];
                        m_f = '0;
                        m_r = '0;
                        m_c = '0;
                        m_seen = m_seen + 1'b1;
                        r.pt = m_next;
                        r.pr = m_next;
                        r.pc = m_next;
                        m_next = pos_add(m_next, 1);
                        m_phase = PH_FIRST_PAD;
                        n_blocks++;
                        if (fin) code = ST_TRUNCATED;
                    end
                end else begin
                    r.pt = m_next;
                    r.pr = m_next;
                    r.pc = m_next;
                    m_next = pos_add(m_next, 1);
                end
                if (code == ST_OK && fin && m_seen != cfg_n_img) code = ST_MISSING;
            end
            if (code != ST_OK) m_err = code;
        end

        if (m_err != ST_OK) begin
            r.pt = '0;
            r.pr = '0;
            r.pc = '0;
            r.img = 1'b0;
        end
        r.st = m_err;
        r.last = fin;
        if (fin) clear_prompt_state();
        return r;
    endfunction

    function automatic tok_item_t drow(logic [TOKEN_W-1:0] tok, logic [FRAMES_W-1:0] f,
                                       logic [SIDE_W-1:0] rw, logic [SIDE_W-1:0] cl,
                                       logic fin, logic typed,
                                       logic [POS_WIDTH-1:0] pos, logic [STATUS_W-1:0] st);
        tok_item_t it;
        it.tok = tok;
        it.frames = f;
        it.rows = rw;
        it.cols = cl;
        it.fin = fin;
        it.typed = typed;
        it.exp.pt = pos;
        it.exp.pr = pos;
        it.exp.pc = pos;
        it.exp.img = 1'b0;
        it.exp.st = st;
        it.exp.last = fin;
        return it;
    endfunction

    // grid fields are don't-care off a vision start, so fill them with noise
    function automatic tok_item_t plain_tok(logic [TOKEN_W-1:0] id);
        tok_item_t it;
        it = '0;
        it.tok = id;
        it.frames = FRAMES_W'($urandom);
        it.rows = SIDE_W'($urandom);
        it.cols = SIDE_W'($urandom);
        return it;
    endfunction

    task automatic pick_grid(input bit big_ok, output logic [FRAMES_W-1:0] gf,
                             output logic [SIDE_W-1:0] gr, output logic [SIDE_W-1:0] gc);
        gf = FRAMES_W'($urandom_range(1, 3));
        gr = SIDE_W'(2 * $urandom_range(1, 3));
        gc = SIDE_W'(2 * $urandom_range(1, 3));
        if (big_ok && !big_done && $urandom_range(29) == 0) begin
            big_done = 1'b1;
            if ($urandom_range(1)) begin
                gf = 8'd255;
                gr = 10'd2;
                gc = 10'd2;
            end else begin
                gf = 8'd1;
                gr = 10'd2;
                gc = 10'd1022;
            end
        end
    endtask

    task automatic build_prompt(input bit big_ok);
        tok_item_t           it;
        int                  n_blk, n_pad, k;
        logic [FRAMES_W-1:0] gf;
        logic [SIDE_W-1:0]   gr, gc;
        logic [TOKEN_W-1:0]  pad;
        bit                  merged;
        prompt_q.delete();
        merged = (cfg_end == cfg_start);
        gf = '0;
        gr = '0;
        gc = '0;
        if ($urandom_range(99) < 80 && cfg_n_img <= 3) begin
            n_blk = cfg_n_img;
        end else begin
            n_blk = $urandom_range(0, 3);
        end
        for (int b = 0; b < n_blk; b++) begin
            // with end == start the end token itself opens the next block
            if (!merged || b == 0) begin
                repeat ($urandom_range(0, 3)) add_tok(plain_tok(TOKEN_W'($urandom)));
                pick_grid(big_ok, gf, gr, gc);
                it = plain_tok(cfg_start);
                it.frames = gf;
                it.rows = gr;
                it.cols = gc;
                add_tok(it);
            end
            pad = $urandom_range(1) ? cfg_img_pad : cfg_vid_pad;
            n_pad = gf * (gr >> 1) * (gc >> 1);
            repeat (n_pad) add_tok(plain_tok(pad));
            it = plain_tok(cfg_end);
            if (merged) begin
                pick_grid(big_ok, gf, gr, gc);
                it.frames = gf;
                it.rows = gr;
                it.cols = gc;
            end
            add_tok(it);
        end
        repeat ($urandom_range(0, 2)) add_tok(plain_tok(TOKEN_W'($urandom)));
        it = plain_tok(TOKEN_W'($urandom));
        it.fin = 1'b1;
        add_tok(it);

        // break about a third of the prompts at one spot
        if ($urandom_range(99) < 30) begin
            k = $urandom_range(0, prompt_q.size() - 1);
            it = prompt_q[k];
            case ($urandom_range(0, 4))
                0: it.tok = TOKEN_W'($urandom);
                1: it.fin = 1'b1;
                2: begin
                    it.tok = cfg_start;
                    it.frames = FRAMES_W'($urandom);
                    it.rows = SIDE_W'($urandom);
                    it.cols = SIDE_W'($urandom);
                end
                3: it.tok = (it.tok == cfg_img_pad) ? cfg_vid_pad : cfg_img_pad;
                default: it.tok = cfg_end;
            endcase
            prompt_q[k] = it;
            if (it.fin) begin
                while (prompt_q.size() > k + 1) void'(prompt_q.pop_back());
            end
        end
    endtask

    task automatic send_token(input tok_item_t it);
        while ($urandom_range(99) < snd_idle_pct) begin
            tok_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        tok_if.valid <= 1'b1;
        tok_if.token_id <= it.tok;
        tok_if.grid_frames <= it.frames;
        tok_if.grid_rows <= it.rows;
        tok_if.grid_cols <= it.cols;
        tok_if.final_token <= it.fin;
        drv_typed = it.typed;
        drv_exp = it.exp;
        @(posedge i_clk);
        while (!tok_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        case (idx)
            CFG_VISION_START:  cfg_start = val;
            CFG_IMAGE_PAD:     cfg_img_pad = val;
            CFG_VIDEO_PAD:     cfg_vid_pad = val;
            CFG_VISION_END:    cfg_end = val;
            CFG_EXPECTED_IMGS: cfg_n_img = val[IMG_CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [TOKEN_W-1:0] vs, input logic [TOKEN_W-1:0] ip,
                                input logic [TOKEN_W-1:0] vp, input logic [TOKEN_W-1:0] ve,
                                input logic [IMG_CNT_W-1:0] n);
        write_reg(CFG_VISION_START, vs);
        write_reg(CFG_IMAGE_PAD, ip);
        write_reg(CFG_VIDEO_PAD, vp);
        write_reg(CFG_VISION_END, ve);
        write_reg(CFG_EXPECTED_IMGS, CFG_DATA_W'(n));
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random(input int n_target, input bit big_ok);
        int sent;
        sent = 0;
        while (sent < n_target) begin
            build_prompt(big_ok);
            foreach (prompt_q[j]) send_token(prompt_q[j]);
            sent += prompt_q.size();
        end
        tok_if.valid <= 1'b0;
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            pos_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (stall_req && !stall_done) begin
            pos_if.ready <= 1'b0;
            stall_left = STALL_CYCLES;
            stall_done = 1'b1;
        end else begin
            pos_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // predict on every accepted token, check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pos_if.valid && pos_if.ready) begin
                n_res_out++;
                got.pt = pos_if.pos_time;
                got.pr = pos_if.pos_row;
                got.pc = pos_if.pos_col;
                got.img = pos_if.is_image_row;
                got.st = pos_if.status;
                got.last = pos_if.last_result;
                st_seen[got.st] = 1'b1;
                if (got.st != ST_OK) n_err_res++;
                if (exp_q.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= MAX_REPORTS) begin
                        $display("result %0d arrived with no token pending", n_res_out);
                    end
                end else begin
                    want = exp_q.pop_front();
                    if (got.pt !== want.pt || got.pr !== want.pr || got.pc !== want.pc ||
                        got.img !== want.img || got.st !== want.st ||
                        got.last !== want.last) begin
                        bad_cnt++;
                        if (bad_cnt <= MAX_REPORTS) begin
                            $display("result %0d: expected t=%0d r=%0d c=%0d img=%0b st=%0d last=%0b",
                                     n_res_out, want.pt, want.pr, want.pc, want.img,
                                     want.st, want.last);
                            $display("result %0d:      got t=%0d r=%0d c=%0d img=%0b st=%0d last=%0b",
                                     n_res_out, got.pt, got.pr, got.pc, got.img,
                                     got.st, got.last);
                        end
                    end
                end
            end
            if (tok_if.valid && tok_if.ready) begin
                n_tok_in++;
                pred = assign_positions(tok_if.token_id, tok_if.grid_frames, tok_if.grid_rows,
                                        tok_if.grid_cols, tok_if.final_token);
                if (drv_typed) pred = drv_exp;
                exp_q.insert(exp_q.size(), pred);
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (tok_if.valid && tok_if.ready) || (pos_if.valid && pos_if.ready)) begin
            quiet_cyc = 0;
        end else begin
            quiet_cyc = quiet_cyc + 1;
        end
        if (quiet_cyc >= WD_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction", quiet_cyc);
            $display("tb_multimodal_token_position_assigner_core failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        tok_if.valid = 1'b0;
        tok_if.token_id = '0;
        tok_if.grid_frames = '0;
        tok_if.grid_rows = '0;
        tok_if.grid_cols = '0;
        tok_if.final_token = 1'b0;
        pos_if.ready = 1'b0;
        drv_exp = '0;
        cfg_start = '0;
        cfg_img_pad = '0;
        cfg_vid_pad = VIDEO_PAD_RESET;
        cfg_end = '0;
        cfg_n_img = '0;
        clear_prompt_state();

        // registers at reset: id 0 opens a block, none expected
        add_row(drow(18'd5,     8'd0,   10'd0,    10'd0,    1'b0, 1'b1, 20'd0, ST_OK));
        add_row(drow(18'h3FFFF, 8'hFF,  10'h3FF,  10'h3FF,  1'b1, 1'b1, 20'd1, ST_OK));
        add_row(drow(18'd0,     8'd255, 10'd1022, 10'd1022, 1'b0, 1'b1, 20'd0,
                     ST_EXTRA_BLOCK));
        add_row(drow(18'd9,     8'd0,   10'd0,    10'd0,    1'b1, 1'b1, 20'd0,
                     ST_EXTRA_BLOCK));
        // programmed ids, one block expected
        add_row(drow(D_START,   8'd2,   10'd4,    10'd2,    1'b0, 1'b0, 20'd0, ST_OK));
        repeat (4) add_row(drow(D_VID, 8'd0, 10'd0, 10'd0,  1'b0, 1'b0, 20'd0, ST_OK));
        add_row(drow(D_END,     8'd0,   10'd0,    10'd0,    1'b1, 1'b0, 20'd0, ST_OK));
        add_row(drow(D_START,   8'd1,   10'd2,    10'd2,    1'b1, 1'b1, 20'd0,
                     ST_TRUNCATED));
        add_row(drow(D_START,   8'd1,   10'd2,    10'd4,    1'b0, 1'b0, 20'd0, ST_OK));
        add_row(drow(D_IMG,     8'd0,   10'd0,    10'd0,    1'b0, 1'b0, 20'd0, ST_OK));
        add_row(drow(D_VID,     8'd0,   10'd0,    10'd0,    1'b0, 1'b0, 20'd0, ST_OK));
        add_row(drow(18'd3,     8'd0,   10'd0,    10'd0,    1'b1, 1'b0, 20'd0, ST_OK));
        add_row(drow(D_START,   8'd255, 10'd1022, 10'd1023, 1'b1, 1'b1, 20'd0,
                     ST_BAD_GRID));
        add_row(drow(D_START,   8'd1,   10'd2,    10'd2,    1'b0, 1'b0, 20'd0, ST_OK));
        add_row(drow(18'd5,     8'd0,   10'd0,    10'd0,    1'b0, 1'b0, 20'd0, ST_OK));
        add_row(drow(18'd6,     8'd0,   10'd0,    10'd0,    1'b1, 1'b0, 20'd0, ST_OK));
        add_row(drow(D_START,   8'd1,   10'd2,    10'd2,    1'b0, 1'b0, 20'd0, ST_OK));
        add_row(drow(D_IMG,     8'd0,   10'd0,    10'd0,    1'b0, 1'b0, 20'd0, ST_OK));
        add_row(drow(18'd7,     8'd0,   10'd0,    10'd0,    1'b1, 1'b0, 20'd0, ST_OK));
        add_row(drow(D_START,   8'd1,   10'd2,    10'd2,    1'b0, 1'b0, 20'd0, ST_OK));
        add_row(drow(D_IMG,     8'd0,   10'd0,    10'd0,    1'b1, 1'b1, 20'd0,
                     ST_TRUNCATED));
        add_row(drow(18'd8,     8'd0,   10'd0,    10'd0,    1'b1, 1'b1, 20'd0,
                     ST_MISSING));

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i]) begin
            if (i == CFG_ROW) begin
                tok_if.valid <= 1'b0;
                wait_drained();
                program_regs(D_START, D_IMG, D_VID, D_END, 8'd1);
            end
            send_token(dir_tab[i]);
        end
        tok_if.valid <= 1'b0;
        wait_drained();

        // sender mostly busy, receiver mostly stalled; ids drawn at random
        begin
            logic [TOKEN_W-1:0] base;
            base = TOKEN_W'($urandom_range(0, 262139));
            program_regs(base, base + 18'd1, base + 18'd2, base + 18'd3,
                         IMG_CNT_W'($urandom_range(1, 3)));
        end
        run_random(RAND_PER_SET, 1'b0);
        wait_drained();

        // swap the idling; end id equals start id, all 255 blocks expected
        snd_idle_pct = 77;
        rcv_idle_pct = 18;
        program_regs(18'd0, 18'h3FFFF, 18'd1, 18'd0, 8'd255);
        run_random(RAND_PER_SET, 1'b0);
        wait_drained();

        // full rate, one long receiver hold-off, one large block allowed
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        program_regs(18'h3FFFF, 18'd5, 18'd5, 18'h3FFFE, 8'd2);
        stall_req = 1'b1;
        run_random(RAND_PER_SET, 1'b1);
        wait_drained();

        if (exp_q.size() != 0) bad_cnt++;
        $display("%0d tokens sent, %0d results checked, %0d image blocks opened by the predictor",
                 n_tok_in, n_res_out, n_blocks);
        $display("%0d results carried an error status; status codes seen (bit per code): %b",
                 n_err_res, st_seen);
        if (bad_cnt == 0) begin
            $display("tb_multimodal_token_position_assigner_core passed");
        end else begin
            $display("%0d mismatching or unexpected results", bad_cnt);
            $display("tb_multimodal_token_position_assigner_core failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/tpa_pkg.sv
design/tpa_in_if.sv
design/tpa_out_if.sv
design/tpa_front.sv
design/tpa_queue.sv
design/tpa_back.sv
design/multimodal_token_position_assigner_core.sv
bench/tb_multimodal_token_position_assigner_core.sv
